>>> rtl/vdt_pkg.sv
`timescale 1ns / 1ps
package vdt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COMP_W      = 32;
  localparam int VIDX_W      = 10;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_NORMALS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TEXCOORDS = 1'd1;

  localparam logic [COMP_W-1:0] ABS_MASK = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] INF_BITS = 32'h7F80_0000;

  typedef struct packed {
    logic [COMP_W-1:0] pos_x;
    logic [COMP_W-1:0] pos_y;
    logic [COMP_W-1:0] pos_z;
    logic [COMP_W-1:0] nrm_x;
    logic [COMP_W-1:0] nrm_y;
    logic [COMP_W-1:0] nrm_z;
    logic [COMP_W-1:0] tex_u;
    logic [COMP_W-1:0] tex_v;
  } vdt_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              is_new;
    logic              table_full;
  } vdt_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } vdt_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic issue;
    logic resolve;
  } vdt_cmd_t;

  typedef struct packed {
    logic any_match;
    logic more;
    logic rd_vld;
    logic cmp_hit;
    logic out_free;
  } vdt_status_t;

  // Float equality: signed zeros are equal, NaN equals nothing.
  function automatic logic feq(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] ma;
    logic [COMP_W-1:0] mb;
    ma = a & ABS_MASK;
    mb = b & ABS_MASK;
    if ((ma > INF_BITS) || (mb > INF_BITS)) begin
      return 1'b0;
    end
    if ((ma == '0) && (mb == '0)) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

>>> rtl/vdt_ctrl.sv
`timescale 1ns / 1ps
module vdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vdt_pkg::vdt_status_t status,
  output vdt_pkg::vdt_cmd_t    cmd
);
  import vdt_pkg::*;

  vdt_state_t state;
  vdt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.any_match ? ST_SCAN : ST_RESOLVE;
        end
      end
      ST_SCAN: begin
        if (status.cmp_hit || (!status.more && !status.rd_vld)) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        // stop fetching once a hit shows up
        cmd.issue = status.more && !status.cmp_hit;
      end
      ST_RESOLVE: begin
        cmd.resolve = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/vdt_dpath.sv
`timescale 1ns / 1ps
module vdt_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  vdt_pkg::vdt_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vdt_pkg::vdt_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [vdt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic                           cfg_data,
  input  vdt_pkg::vdt_cmd_t              cmd,
  output vdt_pkg::vdt_status_t           status
);
  import vdt_pkg::*;

  vdt_in_t          mem [TABLE_DEPTH];
  vdt_in_t          item;
  vdt_in_t          rd_data;
  logic             match_normals;
  logic             match_texcoords;
  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             cmp_hit;
  logic             full;
  logic             append;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_normals   <= 1'b0;
      match_texcoords <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MATCH_NORMALS:   match_normals   <= cfg_data;
        CFG_MATCH_TEXCOORDS: match_texcoords <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmp_hit = rd_vld
      && feq(rd_data.pos_x, item.pos_x)
      && feq(rd_data.pos_y, item.pos_y)
      && feq(rd_data.pos_z, item.pos_z)
      && (!match_normals || (feq(rd_data.nrm_x, item.nrm_x)
                             && feq(rd_data.nrm_y, item.nrm_y)
                             && feq(rd_data.nrm_z, item.nrm_z)))
      && (!match_texcoords || (feq(rd_data.tex_u, item.tex_u)
                               && feq(rd_data.tex_v, item.tex_v)));
  end

  assign full   = (vertex_count == CNT_W'(TABLE_DEPTH));
  assign append = cmd.resolve && !hit_found && !full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
      rd_idx  <= rd_addr[IDX_W-1:0];
    end
    if (append) begin
      mem[vertex_count[IDX_W-1:0]] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      rd_addr      <= '0;
      rd_vld       <= 1'b0;
      hit_found    <= 1'b0;
      hit_idx      <= '0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        rd_addr   <= '0;
        hit_found <= 1'b0;
      end else if (cmd.issue) begin
        rd_addr <= rd_addr + CNT_W'(1);
      end
      if (cmd.scan && cmp_hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (append) begin
        vertex_count <= vertex_count + CNT_W'(1);
      end
    end
  end

  // hold the result until the far side takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      if (hit_found) begin
        out_data.vertex_index <= VIDX_W'(hit_idx);
        out_data.is_new       <= 1'b0;
        out_data.table_full   <= 1'b0;
      end else if (full) begin
        out_data.vertex_index <= '0;
        out_data.is_new       <= 1'b0;
        out_data.table_full   <= 1'b1;
      end else begin
        out_data.vertex_index <= VIDX_W'(vertex_count);
        out_data.is_new       <= 1'b1;
        out_data.table_full   <= 1'b0;
      end
    end
  end

  always_comb begin
    status.any_match = match_normals || match_texcoords;
    status.more      = rd_addr < vertex_count;
    status.rd_vld    = rd_vld;
    status.cmp_hit   = cmp_hit;
    status.out_free  = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_W'(TABLE_DEPTH))
    else $error("vertex count past table depth");

  a_full_no_append: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve && full |=> $stable(vertex_count))
    else $error("append into a full table");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> rd_addr < vertex_count)
    else $error("fetch of an unwritten entry");

  a_resolve_free: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_new && out_data.table_full))
    else $error("result both new and full");

endmodule

>>> rtl/vertex_dedup_table_unit.sv
`timescale 1ns / 1ps
// With matching off an item goes from the idle state straight to resolve. With matching on
// the scan reads one stored entry per cycle from a single-port table,
// stopping at the first hit or once every stored entry has been compared.
// Items are handled one at a time; the next is taken once the one before it resolves.
// Reset clears the entry count, match enables and result valid; no clearing pass.
module vertex_dedup_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vdt_pkg::vdt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vdt_pkg::vdt_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [vdt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic                          cfg_data
);
  import vdt_pkg::*;

  vdt_cmd_t    cmd;
  vdt_status_t status;

  vdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vdt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
